### rtl/roc_pkg.sv
package roc_pkg;

    localparam int MAX_COLS  = 64;
    localparam int MAX_ROWS  = 64;
    localparam int DIM_W     = 7;     // grid_width / grid_height register width
    localparam int CELLS     = MAX_COLS * MAX_ROWS;
    localparam int CELL_W    = $clog2(CELLS);
    localparam int WORD_W    = 64;    // cells per memory word
    localparam int BIT_W     = $clog2(WORD_W);
    localparam int WADDR_W   = CELL_W - BIT_W;
    localparam int NWORDS    = CELLS / WORD_W;
    localparam int SPAN_W    = 14;    // row span end before range check
    localparam int CFG_IDX_W = 1;

    localparam logic [DIM_W-1:0] GRID_WIDTH_RST  = DIM_W'(40);
    localparam logic [DIM_W-1:0] GRID_HEIGHT_RST = DIM_W'(30);

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        FUNC_SET  = 2'd0,
        FUNC_CLR  = 2'd1,
        FUNC_TEST = 2'd2,
        FUNC_NONE = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_RANGE   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_MOD,
        B_REPLY
    } back_state_t;

    // One classified request waiting for the back end.
    typedef struct packed {
        logic [1:0]        func;
        logic [1:0]        status;
        logic              walk;       // touches the memory
        logic [CELL_W-1:0] first;      // first cell of the first row span
        logic [CELL_W-1:0] last;       // last cell of the first row span
        logic [DIM_W-1:0]  rows;
    } roc_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } roc_q_status_t;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] r;
        begin
            if (v == '0)
                r = DIM_W'(1);
            else if (v > hi)
                r = hi;
            else
                r = v;
            return r;
        end
    endfunction

endpackage

### rtl/roc_if.sv
interface roc_req_if;
    import roc_pkg::*;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [5:0]  origin_x;
    logic [5:0]  origin_y;
    logic [12:0] rect_width;
    logic [6:0]  rect_height;

    modport source (output valid, func, origin_x, origin_y, rect_width, rect_height,
                    input ready);
    modport sink   (input valid, func, origin_x, origin_y, rect_width, rect_height,
                    output ready);
endinterface

interface roc_rsp_if;
    logic       valid;
    logic       ready;
    logic       any_set;
    logic [1:0] status;

    modport source (output valid, any_set, status, input ready);
    modport sink   (input valid, any_set, status, output ready);
endinterface

interface roc_cfg_if;
    import roc_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DIM_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### rtl/rect_occupancy_bitmap_core.sv
// Channel  Dir  Payload                                            Word accepted
// req      in   func, origin_x, origin_y, rect_width, rect_height  req.valid & req.ready
// rsp      out  any_set, status                                    rsp.valid & rsp.ready
// cfg      in   index (0 grid_width, 1 grid_height), data          cfg.valid & cfg.ready
//
// Steps: the back end pops a request from the queue, then for each 64-bit bitmap
// word touched, across all covered rows, reads it and then modifies/writes it
// on the single bitmap port, and then loads the reply into the result register;
// rejected or empty requests touch no word and go straight to the reply.
// The front end classifies one word and queues it (2 deep); the back end
// walks the bitmap, so the front keeps taking words while the back is busy.
// Reset clears the registers to 40 x 30 and marks every bitmap word empty at
// once through per-word valid flops; there is no clearing pass.
// A stalled rsp holds the result register; the back end waits in its reply
// state and the queue absorbs up to two further words plus one in the front.
module rect_occupancy_bitmap_core
    import roc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    roc_req_if.sink   req,
    roc_rsp_if.source rsp,
    roc_cfg_if.sink   cfg
);

    logic [DIM_W-1:0] grid_width_reg, grid_width_next;
    logic [DIM_W-1:0] grid_height_reg, grid_height_next;
    logic [DIM_W-1:0] gw;
    logic [DIM_W-1:0] gh;

    logic             push;
    logic             pop;
    roc_entry_t       push_data;
    roc_entry_t       pop_data;
    roc_q_status_t    q_status;

    // Configuration is always taken; writes to unknown indexes are dropped.
    assign cfg.ready = 1'b1;

    always_comb
    begin
        grid_width_next  = grid_width_reg;
        grid_height_next = grid_height_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_GRID_WIDTH:  grid_width_next  = cfg.data;
                CFG_GRID_HEIGHT: grid_height_next = cfg.data;
                default:         grid_width_next  = grid_width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= GRID_WIDTH_RST;
            grid_height_reg <= GRID_HEIGHT_RST;
        end
        else
        begin
            grid_width_reg  <= grid_width_next;
            grid_height_reg <= grid_height_next;
        end
    end

    // Out-of-range register values saturate into 1..MAX when used.
    assign gw = clamp_dim(grid_width_reg, DIM_W'(MAX_COLS));
    assign gh = clamp_dim(grid_height_reg, DIM_W'(MAX_ROWS));

    roc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .gw        (gw),
        .gh        (gh),
        .q_status  (q_status),
        .push      (push),
        .push_data (push_data)
    );

    roc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .q_status  (q_status)
    );

    roc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .gw       (gw),
        .q_status (q_status),
        .pop_data (pop_data),
        .pop      (pop),
        .rsp      (rsp)
    );

endmodule

### rtl/roc_fifo.sv
module roc_fifo
    import roc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  roc_entry_t    push_data,
    input  logic          pop,
    output roc_entry_t    pop_data,
    output roc_q_status_t q_status
);

    roc_entry_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign q_status.full  = (count_reg == 2'd2);
    assign q_status.empty = (count_reg == 2'd0);
    assign pop_data       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

### rtl/roc_front.sv
module roc_front
    import roc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    roc_req_if.sink          req,
    input  logic [DIM_W-1:0] gw,
    input  logic [DIM_W-1:0] gh,
    input  roc_q_status_t    q_status,
    output logic             push,
    output roc_entry_t       push_data
);

    logic             hold_valid_reg, hold_valid_next;
    logic [1:0]       func_reg;
    logic [5:0]       x_reg;
    logic [5:0]       y_reg;
    logic [12:0]      w_reg;
    logic [6:0]       h_reg;

    logic             bad_origin;
    logic [7:0]       last_row;
    logic [DIM_W-1:0] check_row;
    logic [SPAN_W-1:0] span_end;
    logic [SPAN_W-1:0] grid_size;
    logic [SPAN_W-1:0] first_full;
    logic [SPAN_W-1:0] last_full;
    logic [1:0]       status;

    assign req.ready = !hold_valid_reg || !q_status.full;
    assign push      = hold_valid_reg && !q_status.full;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (req.valid && req.ready)
            hold_valid_next = 1'b1;
        else if (push)
            hold_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else
            hold_valid_reg <= hold_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            func_reg <= req.func;
            x_reg    <= req.origin_x;
            y_reg    <= req.origin_y;
            w_reg    <= req.rect_width;
            h_reg    <= req.rect_height;
        end
    end

    // Span end grows with the row, so only the last row below the grid
    // height needs the range check; a row past the height only counts when
    // every earlier row was in range.
    always_comb
    begin
        bad_origin = ({1'b0, x_reg} >= gw) || ({1'b0, y_reg} >= gh);
        last_row   = {2'b0, y_reg} + {1'b0, h_reg} - 8'd1;
        check_row  = (last_row >= {1'b0, gh}) ? (gh - DIM_W'(1)) : last_row[DIM_W-1:0];
        span_end   = SPAN_W'(check_row) * SPAN_W'(gw) + SPAN_W'(x_reg) + SPAN_W'(w_reg);
        grid_size  = SPAN_W'(gw) * SPAN_W'(gh);
        first_full = SPAN_W'(y_reg) * SPAN_W'(gw) + SPAN_W'(x_reg);
        last_full  = first_full + SPAN_W'(w_reg) - SPAN_W'(1);

        if (bad_origin)
            status = ST_BAD_POS;
        else if (h_reg == '0)
            status = ST_OK;
        else if (span_end > grid_size)
            status = ST_RANGE;
        else if (last_row >= {1'b0, gh})
            status = ST_BAD_POS;
        else
            status = ST_OK;

        push_data.func   = func_reg;
        push_data.status = status;
        push_data.walk   = (status == ST_OK) && (w_reg != '0) && (h_reg != '0)
                           && (func_reg != FUNC_NONE);
        push_data.first  = first_full[CELL_W-1:0];
        push_data.last   = last_full[CELL_W-1:0];
        push_data.rows   = h_reg;
    end

endmodule

### rtl/roc_back.sv
module roc_back
    import roc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [DIM_W-1:0] gw,
    input  roc_q_status_t    q_status,
    input  roc_entry_t       pop_data,
    output logic             pop,
    roc_rsp_if.source        rsp
);

    back_state_t       state_reg, state_next;
    logic [1:0]        func_reg;
    logic [1:0]        status_reg;
    logic [CELL_W-1:0] first_reg;
    logic [CELL_W-1:0] last_reg;
    logic [DIM_W-1:0]  rows_reg;
    logic [WADDR_W-1:0] word_reg;
    logic              any_reg;

    logic              rsp_valid_reg, rsp_valid_next;
    logic              rsp_any_reg;
    logic [1:0]        rsp_status_reg;

    // Bitmap: one row-valid flop per word stands in for the reset clear.
    logic [WORD_W-1:0] mem [NWORDS];
    logic [NWORDS-1:0] row_valid_reg;
    logic [WORD_W-1:0] rd_data_reg;
    logic              rd_valid_reg;

    logic              rd_en;
    logic              wr_en;
    logic              out_load;
    logic              row_end;
    logic [BIT_W-1:0]  lo_bit;
    logic [BIT_W-1:0]  hi_bit;
    logic [WORD_W-1:0] mask;
    logic [WORD_W-1:0] cur;
    logic [WORD_W-1:0] wr_data;
    logic [CELL_W-1:0] next_first;

    always_comb
    begin
        lo_bit     = (word_reg == first_reg[CELL_W-1:BIT_W]) ? first_reg[BIT_W-1:0] : '0;
        hi_bit     = (word_reg == last_reg[CELL_W-1:BIT_W]) ? last_reg[BIT_W-1:0] : '1;
        mask       = ({WORD_W{1'b1}} << lo_bit) & ({WORD_W{1'b1}} >> (~hi_bit));
        cur        = rd_valid_reg ? rd_data_reg : '0;
        wr_data    = (func_reg == FUNC_SET) ? (cur | mask) : (cur & ~mask);
        row_end    = (word_reg == last_reg[CELL_W-1:BIT_W]);
        next_first = first_reg + CELL_W'(gw);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_status.empty)
                    state_next = pop_data.walk ? B_READ : B_REPLY;
            end
            B_READ:
                state_next = B_MOD;
            B_MOD:
            begin
                if (row_end && rows_reg == DIM_W'(1))
                    state_next = B_REPLY;
                else
                    state_next = B_READ;
            end
            B_REPLY:
            begin
                if (!rsp_valid_reg || rsp.ready)
                    state_next = B_IDLE;
            end
            default:
                state_next = B_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        pop      = 1'b0;
        rd_en    = 1'b0;
        wr_en    = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            B_IDLE:
                pop = !q_status.empty;
            B_READ:
                rd_en = 1'b1;
            B_MOD:
                wr_en = (func_reg == FUNC_SET) || (func_reg == FUNC_CLR);
            B_REPLY:
                out_load = !rsp_valid_reg || rsp.ready;
            default:
                pop = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= B_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            func_reg   <= pop_data.func;
            status_reg <= pop_data.status;
            first_reg  <= pop_data.first;
            last_reg   <= pop_data.last;
            rows_reg   <= pop_data.rows;
            word_reg   <= pop_data.first[CELL_W-1:BIT_W];
            any_reg    <= 1'b0;
        end
        else if (state_reg == B_MOD)
        begin
            if (func_reg == FUNC_TEST && (cur & mask) != '0)
                any_reg <= 1'b1;
            if (row_end)
            begin
                rows_reg  <= rows_reg - DIM_W'(1);
                first_reg <= next_first;
                last_reg  <= last_reg + CELL_W'(gw);
                word_reg  <= next_first[CELL_W-1:BIT_W];
            end
            else
            begin
                word_reg <= word_reg + WADDR_W'(1);
            end
        end
    end

    // bitmap memory
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[word_reg];
        if (wr_en)
            mem[word_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (rd_en)
                rd_valid_reg <= row_valid_reg[word_reg];
            if (wr_en)
                row_valid_reg[word_reg] <= 1'b1;
        end
    end

    // result register
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (out_load)
            rsp_valid_next = 1'b1;
        else if (rsp.ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else
            rsp_valid_reg <= rsp_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            rsp_any_reg    <= any_reg;
            rsp_status_reg <= status_reg;
        end
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.any_set = rsp_any_reg;
    assign rsp.status  = rsp_status_reg;

endmodule
